[design/tcw_pkg.sv]
// shared types, constants and codes for the text console writer
package tcw_pkg;

    // default screen geometry
    localparam int SCREEN_COLS_DEF = 80;
    localparam int SCREEN_ROWS_DEF = 30;

    // fixed field widths
    localparam int CMD_W       = 2;
    localparam int CHAR_W      = 8;
    localparam int ROW_IN_W    = 5;
    localparam int COL_IN_W    = 7;
    localparam int ROW_OUT_W   = 5;
    localparam int COL_OUT_W   = 7;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 24;

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_BLANK     = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;

    // command codes carried in the input transaction
    typedef enum logic [CMD_W-1:0] {
        CMD_PUT     = 2'd0,
        CMD_SET_ALL = 2'd1,
        CMD_READ    = 2'd2
    } cmd_t;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LATCH,
        OP_CLEAR_START,
        OP_FILL_START,
        OP_SWEEP,
        OP_ADDR_CUR,
        OP_ADDR_READ,
        OP_READ,
        OP_BS_STEP,
        OP_WRITE,
        OP_NEWLINE,
        OP_RETURN,
        OP_SCROLL_START,
        OP_RESULT
    } dp_op_t;

    // controller to datapath
    typedef struct packed {
        dp_op_t op;
    } tcw_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             is_newline;
        logic             is_return;
        logic             is_backspace;
        logic             col_zero;
        logic             past_bottom;
        logic             sweep_last;
        logic             out_full;
    } tcw_stat_t;

endpackage

[design/tcw_ctrl.sv]
// controller state machine sequencing the console datapath
module tcw_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  tcw_pkg::tcw_stat_t stat,
    output tcw_pkg::tcw_cmd_t  cmd
);
    import tcw_pkg::*;

    typedef enum logic [3:0] {
        S_INIT,
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_ADDR,
        S_WRITE,
        S_READ,
        S_SWEEP,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    dp_op_t op_next;

    // next state and datapath operation
    always_comb begin
        state_next = state_reg;
        op_next    = OP_IDLE;
        unique case (state_reg)
            S_INIT: begin
                op_next    = OP_CLEAR_START;
                state_next = S_CLEAR;
            end
            S_CLEAR: begin
                op_next = OP_SWEEP;
                if (stat.sweep_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = OP_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (stat.cmd)
                    CMD_PUT: begin
                        priority if (stat.is_newline) begin
                            op_next    = OP_NEWLINE;
                            state_next = S_RESULT;
                        end else if (stat.is_return) begin
                            op_next    = OP_RETURN;
                            state_next = S_RESULT;
                        end else if (stat.is_backspace) begin
                            if (stat.col_zero) begin
                                state_next = S_RESULT;
                            end else begin
                                op_next    = OP_BS_STEP;
                                state_next = S_ADDR;
                            end
                        end else begin
                            op_next    = OP_ADDR_CUR;
                            state_next = S_WRITE;
                        end
                    end
                    CMD_SET_ALL: begin
                        op_next    = OP_FILL_START;
                        state_next = S_SWEEP;
                    end
                    CMD_READ: begin
                        op_next    = OP_ADDR_READ;
                        state_next = S_READ;
                    end
                    default: begin
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_ADDR: begin
                op_next    = OP_ADDR_CUR;
                state_next = S_WRITE;
            end
            S_WRITE: begin
                op_next    = OP_WRITE;
                state_next = S_RESULT;
            end
            S_READ: begin
                op_next    = OP_READ;
                state_next = S_RESULT;
            end
            S_SWEEP: begin
                op_next = OP_SWEEP;
                if (stat.sweep_last) begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                priority if (stat.past_bottom) begin
                    op_next    = OP_SCROLL_START;
                    state_next = S_SWEEP;
                end else if (!stat.out_full) begin
                    op_next    = OP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    assign cmd.op   = op_next;
    assign s_tready = (state_reg == S_IDLE);

endmodule

[design/tcw_datapath.sv]
// character store, cursor, scroll offset and result register
module tcw_datapath #(
    parameter int SCREEN_COLS = tcw_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = tcw_pkg::SCREEN_ROWS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  tcw_pkg::tcw_cmd_t               cmd,
    output tcw_pkg::tcw_stat_t              stat,
    input  logic [tcw_pkg::CMD_W-1:0]       in_command,
    input  logic [tcw_pkg::CHAR_W-1:0]      in_char_code,
    input  logic [tcw_pkg::ROW_IN_W-1:0]    in_cell_row,
    input  logic [tcw_pkg::COL_IN_W-1:0]    in_cell_col,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tcw_pkg::CHAR_W-1:0]      out_read_char,
    output logic [tcw_pkg::ROW_OUT_W-1:0]   out_cursor_row,
    output logic [tcw_pkg::COL_OUT_W-1:0]   out_cursor_col,
    output logic                            out_scrolled
);
    import tcw_pkg::*;

    localparam int ROW_W  = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
    localparam int COL_W  = (SCREEN_COLS > 1) ? $clog2(SCREEN_COLS) : 1;
    localparam int CELLS  = SCREEN_ROWS * SCREEN_COLS;
    localparam int ADDR_W = $clog2(CELLS);

    // storage
    logic [CHAR_W-1:0] cells_mem [CELLS];

    // latched transaction
    logic [CMD_W-1:0]    lat_cmd_reg;
    logic [CHAR_W-1:0]   lat_char_reg;
    logic [ROW_IN_W-1:0] lat_row_reg;
    logic [COL_IN_W-1:0] lat_col_reg;

    // cursor and scroll state
    logic [ROW_W-1:0] cur_row_reg;
    logic [COL_W-1:0] cur_col_reg;
    logic [ROW_W-1:0] top_reg;
    logic             past_bottom_reg;
    logic             scrolled_reg;

    // address and sweep
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] end_reg;
    logic [CHAR_W-1:0] sweep_data_reg;
    logic              rd_ok_reg;
    logic [CHAR_W-1:0] rd_data_reg;

    // result register
    logic                 out_valid_reg;
    logic [CHAR_W-1:0]    out_char_reg;
    logic [ROW_OUT_W-1:0] out_row_reg;
    logic [COL_OUT_W-1:0] out_col_reg;
    logic                 out_scrolled_reg;

    logic [ROW_W:0]      cur_sum;
    logic [ROW_W-1:0]    cur_phys;
    logic [ROW_W:0]      rd_sum;
    logic [ROW_W-1:0]    rd_phys;
    logic [ADDR_W-1:0]   cur_addr;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   top_base;
    logic                rd_in_range;
    logic                is_backspace;
    logic                col_last;
    logic                row_last;
    logic                mem_we;
    logic [CHAR_W-1:0]   mem_wdata;

    // logical row to physical row through the scroll offset
    always_comb begin
        cur_sum  = {1'b0, cur_row_reg} + {1'b0, top_reg};
        cur_phys = (cur_sum >= (ROW_W+1)'(SCREEN_ROWS))
                 ? ROW_W'(cur_sum - (ROW_W+1)'(SCREEN_ROWS)) : ROW_W'(cur_sum);
        rd_sum   = {1'b0, ROW_W'(32'(lat_row_reg))} + {1'b0, top_reg};
        rd_phys  = (rd_sum >= (ROW_W+1)'(SCREEN_ROWS))
                 ? ROW_W'(rd_sum - (ROW_W+1)'(SCREEN_ROWS)) : ROW_W'(rd_sum);
    end

    // cell addresses
    assign cur_addr    = ADDR_W'(cur_phys) * ADDR_W'(SCREEN_COLS) + ADDR_W'(cur_col_reg);
    assign rd_addr     = ADDR_W'(rd_phys) * ADDR_W'(SCREEN_COLS) + ADDR_W'(lat_col_reg);
    assign top_base    = ADDR_W'(top_reg) * ADDR_W'(SCREEN_COLS);
    assign rd_in_range = (32'(lat_row_reg) < SCREEN_ROWS) && (32'(lat_col_reg) < SCREEN_COLS);

    assign is_backspace = (lat_char_reg == CHAR_BACKSPACE);
    assign col_last     = (cur_col_reg == COL_W'(SCREEN_COLS - 1));
    assign row_last     = (cur_row_reg == ROW_W'(SCREEN_ROWS - 1));

    // memory write selection
    assign mem_we    = (cmd.op == OP_WRITE) || (cmd.op == OP_SWEEP);
    assign mem_wdata = (cmd.op == OP_SWEEP) ? sweep_data_reg
                     : (is_backspace ? CHAR_BLANK : lat_char_reg);

    // character store with registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cells_mem[addr_reg] <= mem_wdata;
        end
        if (cmd.op == OP_READ) begin
            rd_data_reg <= cells_mem[addr_reg];
        end
    end

    // cursor, scroll offset and flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_row_reg     <= '0;
            cur_col_reg     <= '0;
            top_reg         <= '0;
            past_bottom_reg <= 1'b0;
            scrolled_reg    <= 1'b0;
        end else begin
            unique case (cmd.op)
                OP_LATCH: begin
                    scrolled_reg <= 1'b0;
                end
                OP_CLEAR_START, OP_FILL_START: begin
                    cur_row_reg <= '0;
                    cur_col_reg <= '0;
                    top_reg     <= '0;
                end
                OP_BS_STEP: begin
                    cur_col_reg <= cur_col_reg - COL_W'(1);
                end
                OP_WRITE: begin
                    if (!is_backspace) begin
                        if (col_last) begin
                            cur_col_reg <= '0;
                            if (row_last) begin
                                past_bottom_reg <= 1'b1;
                            end else begin
                                cur_row_reg <= cur_row_reg + ROW_W'(1);
                            end
                        end else begin
                            cur_col_reg <= cur_col_reg + COL_W'(1);
                        end
                    end
                end
                OP_NEWLINE: begin
                    cur_col_reg <= '0;
                    if (row_last) begin
                        past_bottom_reg <= 1'b1;
                    end else begin
                        cur_row_reg <= cur_row_reg + ROW_W'(1);
                    end
                end
                OP_RETURN: begin
                    cur_col_reg <= '0;
                end
                OP_SCROLL_START: begin
                    past_bottom_reg <= 1'b0;
                    scrolled_reg    <= 1'b1;
                    top_reg         <= (top_reg == ROW_W'(SCREEN_ROWS - 1))
                                     ? '0 : top_reg + ROW_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // transaction latch, addressing and sweep control
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LATCH: begin
                lat_cmd_reg  <= in_command;
                lat_char_reg <= in_char_code;
                lat_row_reg  <= in_cell_row;
                lat_col_reg  <= in_cell_col;
            end
            OP_CLEAR_START: begin
                addr_reg       <= '0;
                end_reg        <= ADDR_W'(CELLS - 1);
                sweep_data_reg <= CHAR_BLANK;
            end
            OP_FILL_START: begin
                addr_reg       <= '0;
                end_reg        <= ADDR_W'(CELLS - 1);
                sweep_data_reg <= lat_char_reg;
            end
            OP_SCROLL_START: begin
                // old top row becomes the new bottom row, blank it
                addr_reg       <= top_base;
                end_reg        <= top_base + ADDR_W'(SCREEN_COLS - 1);
                sweep_data_reg <= CHAR_BLANK;
            end
            OP_SWEEP: begin
                addr_reg <= addr_reg + ADDR_W'(1);
            end
            OP_ADDR_CUR: begin
                addr_reg <= cur_addr;
            end
            OP_ADDR_READ: begin
                addr_reg  <= rd_addr;
                rd_ok_reg <= rd_in_range;
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.op == OP_RESULT) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_RESULT) begin
            out_char_reg     <= ((lat_cmd_reg == CMD_READ) && rd_ok_reg) ? rd_data_reg : '0;
            out_row_reg      <= ROW_OUT_W'(cur_row_reg);
            out_col_reg      <= COL_OUT_W'(cur_col_reg);
            out_scrolled_reg <= scrolled_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_read_char  = out_char_reg;
    assign out_cursor_row = out_row_reg;
    assign out_cursor_col = out_col_reg;
    assign out_scrolled   = out_scrolled_reg;

    // status to the controller
    assign stat.cmd          = lat_cmd_reg;
    assign stat.is_newline   = (lat_char_reg == CHAR_NEWLINE);
    assign stat.is_return    = (lat_char_reg == CHAR_RETURN);
    assign stat.is_backspace = is_backspace;
    assign stat.col_zero     = (cur_col_reg == '0);
    assign stat.past_bottom  = past_bottom_reg;
    assign stat.sweep_last   = (addr_reg == end_reg);
    assign stat.out_full     = out_valid_reg;

    // a pending scroll only ever comes from the bottom row
    a_past_bottom_row: assert property (@(posedge aclk) disable iff (!aresetn)
        past_bottom_reg |-> row_last)
        else $error("pending scroll off the bottom row");

    // cursor and offset stay on the screen
    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(cur_col_reg) < SCREEN_COLS) && (32'(cur_row_reg) < SCREEN_ROWS)
        && (32'(top_reg) < SCREEN_ROWS))
        else $error("cursor or scroll offset outside the screen");

    // a new result never overwrites one not yet taken
    a_result_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_RESULT) |-> !out_valid_reg)
        else $error("result register overwritten");

    // writes stay inside the store
    a_write_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (32'(addr_reg) < CELLS))
        else $error("store write out of range");

endmodule

[design/text_console_writer.sv]
// top level of the text console writer: stream ports, controller and datapath
//
// Teletype-style console holding a SCREEN_ROWS x SCREEN_COLS character store
// and a cursor. Each input transaction carries one command (put, fill, read)
// and gives exactly one result transaction with the read character, the
// cursor after the command and a scroll flag.
// Steps per transaction, from acceptance to the next possible acceptance,
// receiver ready (the result goes valid at the last of these steps):
//   return, newline, ignored backspace, unused command: decode, result
//   printable byte, read: decode and address, store write or read, result
//   backspace that steps left: decode and step left, address, write, result
//   scroll adds a scroll start and a row sweep (one store write per cycle to blank
//   the new bottom row; rows are remapped through a rotating top-row offset)
//   fill: decode, a sweep over every cell, one cell per cycle, result
// One item is in work at a time; the single-port store sets these steps.
// After reset the store is swept to space, during which s_tready stays low;
// cursor is homed.
// The result sits in an output register until m_tready takes it. A new input
// transaction is accepted while that result waits; its own result then holds
// in the controller until the register frees.
module text_console_writer #(
    parameter int SCREEN_COLS = tcw_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = tcw_pkg::SCREEN_ROWS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // command [1:0], char_code [9:2], cell_row [14:10], cell_col [21:15]
    input  logic [tcw_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // read_char [7:0], cursor_row [12:8], cursor_col [19:13], scrolled [20]
    output logic [tcw_pkg::M_TDATA_W-1:0]   m_tdata
);
    import tcw_pkg::*;

    tcw_cmd_t  dp_cmd;
    tcw_stat_t dp_stat;

    logic [CHAR_W-1:0]    read_char;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [COL_OUT_W-1:0] cursor_col;
    logic                 scrolled;

    // controller
    tcw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    // datapath with input field unpacking
    tcw_datapath #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (dp_cmd),
        .stat           (dp_stat),
        .in_command     (s_tdata[1:0]),
        .in_char_code   (s_tdata[9:2]),
        .in_cell_row    (s_tdata[14:10]),
        .in_cell_col    (s_tdata[21:15]),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_read_char  (read_char),
        .out_cursor_row (cursor_row),
        .out_cursor_col (cursor_col),
        .out_scrolled   (scrolled)
    );

    // result packing
    assign m_tdata = {3'b000, scrolled, cursor_col, cursor_row, read_char};

endmodule
